// ===== rtl/lfs_pkg.sv =====
`default_nettype none

package lfs_pkg;

    // timing and output scaling
    localparam int TICK_MS      = 10;
    localparam int PWM_BITS     = 10;
    localparam int PWM_MAX      = (1 << PWM_BITS) - 1;
    localparam int PWM_INT      = PWM_MAX / 255;
    localparam int PWM_FRAC     = PWM_MAX % 255;
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    // pattern positions
    localparam logic [5:0] POS_TOP     = 6'd0;
    localparam logic [5:0] POS_LOOP    = 6'd1;
    localparam logic [5:0] NORMAL_IDLE = 6'd4;
    localparam logic [5:0] POS_TRANS   = 6'd63;

    // one tick runs at most this many pattern steps plus one
    localparam logic [6:0] GUARD_LAST = 7'd127;

    // request codes above this one are dropped
    localparam logic [2:0] REQ_CODE_MAX = 3'd4;

    // register map, selected by paddr[2]
    localparam logic REG_BRIGHTNESS      = 1'b0;
    localparam logic REG_BREATH_INTERVAL = 1'b1;

    localparam logic [6:0]  BRIGHT_RST   = 7'd100;
    localparam logic [15:0] INTERVAL_RST = 16'd1000;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NORMAL  = 3'd2,
        MODE_LEARN   = 3'd3,
        MODE_RESET   = 3'd4,
        MODE_FACTORY = 3'd5,
        MODE_NONE    = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        K_TOP     = 4'd0,
        K_BREATH  = 4'd1,
        K_ON      = 4'd2,
        K_OFF     = 4'd3,
        K_FADE    = 4'd4,
        K_WAIT    = 4'd5,
        K_SETNORM = 4'd6,
        K_END     = 4'd7,
        K_TRANS   = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LERP_GO,
        S_LERP_WAIT,
        S_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_NEXT
    } t_lerp_state;

    typedef enum logic [1:0] {
        O_IDLE,
        O_MUL,
        O_DIV,
        O_PWM
    } t_out_state;

    typedef struct packed {
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] v;
    } t_hsv;

    // one control word of the pattern program
    typedef struct packed {
        t_kind      kind;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] ticks;
    } t_op;

    typedef struct packed {
        logic       go;
        t_hsv       from;
        t_hsv       to;
        logic [7:0] index;
        logic [7:0] total;
    } t_lerp_req;

    typedef struct packed {
        t_hsv  color;
        t_mode mode;
    } t_result;

    function automatic logic [7:0] ms_ticks(input int ms);
        int t;
        t = ms / TICK_MS;
        return (t > 255) ? 8'd255 : 8'(t);
    endfunction

    function automatic t_op mk_op(input t_kind kind, input logic [7:0] hue,
                                  input logic [7:0] sat, input logic [7:0] val,
                                  input int ms);
        t_op op;
        op.kind  = kind;
        op.hue   = hue;
        op.sat   = sat;
        op.val   = val;
        op.ticks = ms_ticks(ms);
        return op;
    endfunction

    // identify flash colors: blue, orange, green, red
    function automatic logic [7:0] flash_hue(input logic [1:0] idx);
        logic [7:0] h;
        unique case (idx)
            2'd0:    h = 8'd160;
            2'd1:    h = 8'd32;
            2'd2:    h = 8'd96;
            default: h = 8'd0;
        endcase
        return h;
    endfunction

    // pattern program rom, one table per mode
    function automatic t_op op_rom(input t_mode mode, input logic [5:0] pos);
        t_op        op;
        logic [5:0] k;
        op = mk_op(K_END, 8'd0, 8'd0, 8'd0, 0);
        k  = pos - 6'd1;
        unique case (mode)
            MODE_IDENT: begin
                if (pos == POS_TOP) begin
                    op = mk_op(K_TOP, 8'd0, 8'd0, 8'd0, 0);
                end else if (pos <= 6'd32) begin
                    unique case (k[1:0])
                        2'd0:    op = mk_op(K_ON, flash_hue(k[3:2]), 8'd255, 8'd0, 100);
                        2'd1:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                        2'd2:    op = mk_op(K_OFF, 8'd0, 8'd0, 8'd0, 100);
                        default: op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                    endcase
                end else if (pos == 6'd33) begin
                    op = mk_op(K_SETNORM, 8'd0, 8'd0, 8'd0, 0);
                end
            end
            MODE_NORMAL: begin
                unique case (pos)
                    6'd0:    op = mk_op(K_TOP, 8'd0, 8'd0, 8'd0, 0);
                    6'd1:    op = mk_op(K_BREATH, 8'd0, 8'd0, 8'd0, 0);
                    6'd2:    op = mk_op(K_ON, 8'd96, 8'd255, 8'd0, 1500);
                    6'd3:    op = mk_op(K_OFF, 8'd0, 8'd0, 8'd0, 1500);
                    6'd4:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                    default: op = mk_op(K_END, 8'd0, 8'd0, 8'd0, 0);
                endcase
            end
            MODE_LEARN: begin
                unique case (pos)
                    6'd0:    op = mk_op(K_TOP, 8'd0, 8'd0, 8'd0, 0);
                    6'd1:    op = mk_op(K_FADE, 8'd0, 8'd200, 8'd255, 100);
                    6'd2:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                    default: op = mk_op(K_END, 8'd0, 8'd0, 8'd0, 0);
                endcase
            end
            MODE_RESET: begin
                unique case (pos)
                    6'd0:    op = mk_op(K_TOP, 8'd0, 8'd0, 8'd0, 0);
                    6'd1:    op = mk_op(K_FADE, 8'd160, 8'd200, 8'd255, 100);
                    6'd2:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 200);
                    6'd3:    op = mk_op(K_OFF, 8'd0, 8'd0, 8'd0, 100);
                    6'd4:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 180);
                    6'd5:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                    default: op = mk_op(K_END, 8'd0, 8'd0, 8'd0, 0);
                endcase
            end
            MODE_FACTORY: begin
                unique case (pos)
                    6'd0:    op = mk_op(K_TOP, 8'd0, 8'd0, 8'd0, 0);
                    6'd1:    op = mk_op(K_FADE, 8'd0, 8'd200, 8'd255, 100);
                    6'd2:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 50);
                    6'd3:    op = mk_op(K_OFF, 8'd0, 8'd0, 8'd0, 100);
                    6'd4:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 30);
                    6'd5:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                    default: op = mk_op(K_END, 8'd0, 8'd0, 8'd0, 0);
                endcase
            end
            default: begin
                // off: idle wait only
                unique case (pos)
                    6'd0:    op = mk_op(K_TOP, 8'd0, 8'd0, 8'd0, 0);
                    6'd1:    op = mk_op(K_WAIT, 8'd0, 8'd0, 8'd0, 20);
                    default: op = mk_op(K_END, 8'd0, 8'd0, 8'd0, 0);
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/led_indicator_fade_sequencer.sv =====
`default_nettype none

// Status-LED pattern sequencer.
// Input channel (i_valid/o_ready): each beat is either a 10 ms tick (i_mode = 0)
// or a state request (i_mode = 1, i_requested_state). Every beat gives exactly one
// result beat on the output channel (o_valid/i_ready) with hue, saturation, the
// brightness-scaled value, the PWM duty and the indicator state after that beat.
// Path from the accepting edge to o_valid: a request beat goes straight to the
// result step; a tick steps through its jump words, one a cycle, to a wait or a
// fade step, and a fade step runs the interpolation unit (per channel one
// multiply, eight quotient bits and one write step). The output stage then runs
// scale multiply, divide by 100 and duty map, and takes a new result only once
// it has handed the last one to its output register.
// One beat is worked on at a time; the next beat is accepted the cycle after the
// result is handed to the output stage, even while o_valid waits on i_ready.
// When the receiver stalls, the result register holds, the output stage keeps one
// more result and the sequencer finishes one more beat, then o_ready drops.
// Reset (synchronous, active low) starts in normal mode with the color off and
// the breath timer at zero, so the first tick starts a breath. Brightness resets
// to 100 percent and the breath interval to 1000 ticks, at APB byte addresses
// 0 and 4; the user writes them only while the block is idle; no check enforces it.

module led_indicator_fade_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [2:0]  i_requested_state,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_hue,
    output logic [7:0]       o_saturation,
    output logic [7:0]       o_dimmed_value,
    output logic [9:0]       o_pwm_duty,
    output logic [2:0]       o_indicator_state,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0]  r_bright;
    logic [15:0] r_interval;

    lfs_pkg::t_lerp_req w_lerp;
    logic               w_lerp_done;
    lfs_pkg::t_hsv      w_lerp_color;
    logic               w_load;
    lfs_pkg::t_result   w_result;
    logic               w_out_idle;
    logic               w_wr;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright   <= lfs_pkg::BRIGHT_RST;
            r_interval <= lfs_pkg::INTERVAL_RST;
        end else if (w_wr) begin
            if (paddr[2] == lfs_pkg::REG_BRIGHTNESS) begin
                r_bright <= pwdata[6:0];
            end else begin
                r_interval <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == lfs_pkg::REG_BREATH_INTERVAL) ? {16'd0, r_interval}
                                                                : {25'd0, r_bright};

    // pattern program sequencer
    lfs_sequencer u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_requested_state (i_requested_state),
        .i_interval        (r_interval),
        .o_lerp            (w_lerp),
        .i_lerp_done       (w_lerp_done),
        .i_lerp_color      (w_lerp_color),
        .o_load            (w_load),
        .o_result          (w_result),
        .i_out_idle        (w_out_idle)
    );

    // fade interpolation
    lfs_lerp_unit u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lerp),
        .o_done  (w_lerp_done),
        .o_color (w_lerp_color)
    );

    // brightness scaling, duty mapping and result register
    lfs_out_stage u_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_load),
        .i_result          (w_result),
        .i_brightness      (r_bright),
        .o_idle            (w_out_idle),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_hue             (o_hue),
        .o_saturation      (o_saturation),
        .o_dimmed_value    (o_dimmed_value),
        .o_pwm_duty        (o_pwm_duty),
        .o_indicator_state (o_indicator_state)
    );

endmodule

`default_nettype wire

// ===== rtl/lfs_lerp_unit.sv =====
`default_nettype none

module lfs_lerp_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lfs_pkg::t_lerp_req i_req,
    output logic                   o_done,
    output lfs_pkg::t_hsv          o_color
);

    lfs_pkg::t_lerp_state r_state, n_state;
    logic [1:0]  r_ch, n_ch;
    logic        r_neg, n_neg;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_quo, n_quo;
    logic [2:0]  r_bit, n_bit;
    logic        r_done, n_done;
    lfs_pkg::t_hsv r_res, n_res;

    logic [7:0]  w_from_ch;
    logic [7:0]  w_to_ch;
    logic [7:0]  w_mag;
    logic [15:0] w_trial;
    logic [7:0]  w_sum;

    // channel select
    always_comb begin
        unique case (r_ch)
            2'd0: begin
                w_from_ch = i_req.from.h;
                w_to_ch   = i_req.to.h;
            end
            2'd1: begin
                w_from_ch = i_req.from.s;
                w_to_ch   = i_req.to.s;
            end
            default: begin
                w_from_ch = i_req.from.v;
                w_to_ch   = i_req.to.v;
            end
        endcase
    end

    assign w_mag   = (w_to_ch >= w_from_ch) ? (w_to_ch - w_from_ch) : (w_from_ch - w_to_ch);
    assign w_trial = {8'd0, i_req.total} << r_bit;
    assign w_sum   = r_neg ? (w_from_ch - r_quo) : (w_from_ch + r_quo);

    // control and datapath: multiply, then one quotient bit a cycle
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_bit   = r_bit;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            lfs_pkg::L_IDLE: begin
                if (i_req.go) begin
                    n_ch    = 2'd0;
                    n_state = lfs_pkg::L_MUL;
                end
            end
            lfs_pkg::L_MUL: begin
                n_neg   = w_to_ch < w_from_ch;
                n_rem   = {8'd0, w_mag} * {8'd0, i_req.index};
                n_quo   = 8'd0;
                n_bit   = 3'd7;
                n_state = lfs_pkg::L_DIV;
            end
            lfs_pkg::L_DIV: begin
                if (r_rem >= w_trial) begin
                    n_rem        = r_rem - w_trial;
                    n_quo[r_bit] = 1'b1;
                end
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    n_state = lfs_pkg::L_NEXT;
                end
            end
            default: begin
                unique case (r_ch)
                    2'd0:    n_res.h = w_sum;
                    2'd1:    n_res.s = w_sum;
                    default: n_res.v = w_sum;
                endcase
                if (r_ch == 2'd2) begin
                    n_done  = 1'b1;
                    n_state = lfs_pkg::L_IDLE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = lfs_pkg::L_MUL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfs_pkg::L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_ch  <= n_ch;
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_bit <= n_bit;
        r_res <= n_res;
    end

    assign o_done  = r_done;
    assign o_color = r_res;

endmodule

`default_nettype wire

// ===== rtl/lfs_out_stage.sv =====
`default_nettype none

module lfs_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire lfs_pkg::t_result i_result,
    input  wire logic [6:0]       i_brightness,
    output logic                  o_idle,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_hue,
    output logic [7:0]            o_saturation,
    output logic [7:0]            o_dimmed_value,
    output logic [9:0]            o_pwm_duty,
    output logic [2:0]            o_indicator_state
);

    lfs_pkg::t_out_state r_state, n_state;
    lfs_pkg::t_result    r_item;
    logic [14:0] r_prod;
    logic [7:0]  r_dim;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_hue, r_sat, r_dimo;
    logic [9:0]  r_pwm;
    logic [2:0]  r_ind;

    logic [27:0] w_scaled;
    logic [8:0]  w_quot;
    logic [15:0] w_frac_x;
    logic [15:0] w_frac_sum;
    logic [17:0] w_pwm_full;
    logic        w_emit;

    // divide by 100 through a reciprocal multiply
    assign w_scaled = {13'd0, r_prod} * 28'(lfs_pkg::DIV100_MUL);
    assign w_quot   = w_scaled[lfs_pkg::DIV100_SHIFT +: 9];

    // duty = dim * PWM_MAX / 255, split into integer and fractional multiples of 255
    assign w_frac_x   = {8'd0, r_dim} * 16'(lfs_pkg::PWM_FRAC);
    assign w_frac_sum = w_frac_x + 16'd1 + (w_frac_x >> 8);
    assign w_pwm_full = {10'd0, r_dim} * 18'(lfs_pkg::PWM_INT) + {10'd0, w_frac_sum[15:8]};

    assign w_emit = (r_state == lfs_pkg::O_PWM) && (!r_ovalid || i_ready);

    // output stage sequencing
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            lfs_pkg::O_IDLE: begin
                if (i_load) begin
                    n_state = lfs_pkg::O_MUL;
                end
            end
            lfs_pkg::O_MUL: n_state = lfs_pkg::O_DIV;
            lfs_pkg::O_DIV: n_state = lfs_pkg::O_PWM;
            default: begin
                if (w_emit) begin
                    n_ovalid = 1'b1;
                    n_state  = lfs_pkg::O_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lfs_pkg::O_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        if (i_load && r_state == lfs_pkg::O_IDLE) begin
            r_item <= i_result;
        end
        r_prod <= {7'd0, r_item.color.v} * {8'd0, i_brightness};
        r_dim  <= (w_quot > 9'd255) ? 8'd255 : w_quot[7:0];
        if (w_emit) begin
            r_hue  <= r_item.color.h;
            r_sat  <= r_item.color.s;
            r_dimo <= r_dim;
            r_pwm  <= w_pwm_full[9:0];
            r_ind  <= r_item.mode;
        end
    end

    assign o_idle            = (r_state == lfs_pkg::O_IDLE);
    assign o_valid           = r_ovalid;
    assign o_hue             = r_hue;
    assign o_saturation      = r_sat;
    assign o_dimmed_value    = r_dimo;
    assign o_pwm_duty        = r_pwm;
    assign o_indicator_state = r_ind;

endmodule

`default_nettype wire

// ===== rtl/lfs_sequencer.sv =====
`default_nettype none

module lfs_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_mode,
    input  wire logic [2:0]         i_requested_state,
    input  wire logic [15:0]        i_interval,
    output lfs_pkg::t_lerp_req      o_lerp,
    input  wire logic               i_lerp_done,
    input  wire lfs_pkg::t_hsv      i_lerp_color,
    output logic                    o_load,
    output lfs_pkg::t_result        o_result,
    input  wire logic               i_out_idle
);

    lfs_pkg::t_seq_state r_state, n_state;
    lfs_pkg::t_mode      r_mode, n_mode;
    lfs_pkg::t_mode      r_pending, n_pending;
    lfs_pkg::t_hsv       r_cur, n_cur;
    lfs_pkg::t_hsv       r_from, n_from;
    lfs_pkg::t_hsv       r_to, n_to;
    logic [7:0]  r_index, n_index;
    logic [7:0]  r_total, n_total;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_breath, n_breath;
    logic        r_active, n_active;
    logic [6:0]  r_guard, n_guard;

    lfs_pkg::t_op  w_op;
    lfs_pkg::t_hsv w_start;
    lfs_pkg::t_hsv w_goal;
    logic [7:0]    w_hold;
    logic          w_finish;
    logic          w_cont;
    logic          w_accept;

    assign w_accept = i_valid && o_ready;

    // fetch the control word at the step counter
    always_comb begin
        if (r_pos == lfs_pkg::POS_TRANS) begin
            w_op = lfs_pkg::mk_op(lfs_pkg::K_TRANS, 8'd0, 8'd0, 8'd0, 100);
        end else begin
            w_op = lfs_pkg::op_rom(r_mode, r_pos);
        end
    end

    // fade endpoints for a new fade
    always_comb begin
        w_start = r_cur;
        w_goal  = r_cur;
        case (w_op.kind)
            lfs_pkg::K_ON: begin
                w_start = '{h: w_op.hue, s: w_op.sat, v: 8'd0};
                w_goal  = '{h: w_op.hue, s: w_op.sat, v: 8'd255};
            end
            lfs_pkg::K_FADE: begin
                w_goal = '{h: w_op.hue, s: w_op.sat, v: w_op.val};
            end
            default: begin
                w_goal.v = 8'd0;
            end
        endcase
    end

    assign w_hold = r_active ? r_hold : w_op.ticks;

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_pending = r_pending;
        n_cur     = r_cur;
        n_from    = r_from;
        n_to      = r_to;
        n_index   = r_index;
        n_total   = r_total;
        n_pos     = r_pos;
        n_hold    = r_hold;
        n_breath  = r_breath;
        n_active  = r_active;
        n_guard   = r_guard;
        w_finish  = 1'b0;
        w_cont    = 1'b0;
        o_load    = 1'b0;
        unique case (r_state)
            lfs_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_mode) begin
                        if (i_requested_state <= lfs_pkg::REQ_CODE_MAX) begin
                            n_pending = lfs_pkg::t_mode'(i_requested_state + 3'd1);
                        end
                        n_state = lfs_pkg::S_OUT;
                    end else begin
                        if (r_breath != 16'd0) begin
                            n_breath = r_breath - 16'd1;
                        end
                        n_guard = 7'd0;
                        n_state = lfs_pkg::S_FETCH;
                    end
                end
            end
            lfs_pkg::S_FETCH: begin
                unique case (w_op.kind)
                    lfs_pkg::K_TOP: begin
                        w_cont = 1'b1;
                        if (r_pending == lfs_pkg::MODE_NONE) begin
                            n_pos = lfs_pkg::POS_LOOP;
                        end else if (r_pending == r_mode || r_mode == lfs_pkg::MODE_OFF) begin
                            n_mode    = r_pending;
                            n_pending = lfs_pkg::MODE_NONE;
                            n_pos     = lfs_pkg::POS_LOOP;
                        end else begin
                            n_pos = lfs_pkg::POS_TRANS;
                        end
                    end
                    lfs_pkg::K_BREATH: begin
                        w_cont = 1'b1;
                        if (r_breath == 16'd0) begin
                            n_breath = i_interval;
                            n_pos    = r_pos + 6'd1;
                        end else begin
                            n_pos = lfs_pkg::NORMAL_IDLE;
                        end
                    end
                    lfs_pkg::K_SETNORM: begin
                        w_cont = 1'b1;
                        n_mode = lfs_pkg::MODE_NORMAL;
                        n_pos  = lfs_pkg::NORMAL_IDLE;
                    end
                    lfs_pkg::K_END: begin
                        w_cont = 1'b1;
                        n_pos  = lfs_pkg::POS_TOP;
                    end
                    lfs_pkg::K_WAIT: begin
                        if (!r_active && w_op.ticks == 8'd0) begin
                            w_finish = 1'b1;
                            w_cont   = 1'b1;
                        end else begin
                            n_active = 1'b1;
                            n_hold   = w_hold - 8'd1;
                            w_finish = (w_hold == 8'd1);
                            n_state  = lfs_pkg::S_OUT;
                        end
                    end
                    default: begin
                        // fades: on, off, to a color, and the mode-change fade
                        if (!r_active) begin
                            n_from   = w_start;
                            n_to     = w_goal;
                            n_total  = w_op.ticks;
                            n_active = 1'b1;
                            if (w_op.ticks <= 8'd1) begin
                                n_index  = 8'd0;
                                n_cur    = w_goal;
                                w_finish = 1'b1;
                                w_cont   = 1'b1;
                            end else begin
                                n_index = 8'd1;
                                n_state = lfs_pkg::S_LERP_GO;
                            end
                        end else begin
                            n_index = r_index + 8'd1;
                            n_state = lfs_pkg::S_LERP_GO;
                        end
                    end
                endcase
                // bound on pattern steps within one tick
                if (w_cont) begin
                    n_guard = r_guard + 7'd1;
                    if (r_guard == lfs_pkg::GUARD_LAST) begin
                        n_state = lfs_pkg::S_OUT;
                    end
                end
            end
            lfs_pkg::S_LERP_GO: begin
                n_state = lfs_pkg::S_LERP_WAIT;
            end
            lfs_pkg::S_LERP_WAIT: begin
                if (i_lerp_done) begin
                    n_cur    = i_lerp_color;
                    w_finish = (r_index >= r_total);
                    n_state  = lfs_pkg::S_OUT;
                end
            end
            default: begin
                if (i_out_idle) begin
                    o_load  = 1'b1;
                    n_state = lfs_pkg::S_IDLE;
                end
            end
        endcase

        // end of a timed step: advance, or take the mode after the change fade
        if (w_finish) begin
            n_active = 1'b0;
            if (r_pos == lfs_pkg::POS_TRANS) begin
                if (r_pending >= lfs_pkg::MODE_IDENT && r_pending <= lfs_pkg::MODE_FACTORY) begin
                    n_mode = r_pending;
                end
                n_pending = lfs_pkg::MODE_NONE;
                n_pos     = lfs_pkg::POS_LOOP;
            end else begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lfs_pkg::S_IDLE;
            r_mode    <= lfs_pkg::MODE_NORMAL;
            r_pending <= lfs_pkg::MODE_NONE;
            r_cur     <= '0;
            r_from    <= '0;
            r_to      <= '0;
            r_index   <= 8'd0;
            r_total   <= 8'd0;
            r_pos     <= lfs_pkg::POS_TOP;
            r_hold    <= 8'd0;
            r_breath  <= 16'd0;
            r_active  <= 1'b0;
            r_guard   <= 7'd0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_cur     <= n_cur;
            r_from    <= n_from;
            r_to      <= n_to;
            r_index   <= n_index;
            r_total   <= n_total;
            r_pos     <= n_pos;
            r_hold    <= n_hold;
            r_breath  <= n_breath;
            r_active  <= n_active;
            r_guard   <= n_guard;
        end
    end

    assign o_ready        = (r_state == lfs_pkg::S_IDLE);
    assign o_lerp.go      = (r_state == lfs_pkg::S_LERP_GO);
    assign o_lerp.from    = r_from;
    assign o_lerp.to      = r_to;
    assign o_lerp.index   = r_index;
    assign o_lerp.total   = r_total;
    assign o_result.color = r_cur;
    assign o_result.mode  = r_mode;

    // fade step never runs past its step count
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= r_total)
        else $error("fade step index beyond step count");

    // an accepted item always starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == lfs_pkg::S_FETCH || r_state == lfs_pkg::S_OUT))
        else $error("accepted item did not start");

    // interpolation result only arrives while waiting for it
    a_lerp_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_lerp_done |-> r_state == lfs_pkg::S_LERP_WAIT)
        else $error("unexpected interpolation result");

    // the mode register never holds the empty request code
    a_mode_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != lfs_pkg::MODE_NONE)
        else $error("indicator mode took the empty request code");

endmodule

`default_nettype wire
